/* hw/rtl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// Serpent cipher package
// Shared types, constants and round functions for the Serpent core.
// ----------------------------------------------------------------------------
`default_nettype none
package srp_pkg;

  localparam int unsigned NumRoundKeys = 33;
  localparam int unsigned NumRounds    = 32;
  localparam int unsigned NumCfgRegs   = 4;
  localparam logic [31:0] PhiWord      = 32'h9e3779b9;

  typedef logic [5:0] rk_idx_t;

  localparam logic [1:0] CfgKeyLowPair    = 2'd0;
  localparam logic [1:0] CfgKeySecondPair = 2'd1;
  localparam logic [1:0] CfgKeyThirdPair  = 2'd2;
  localparam logic [1:0] CfgKeyHighPair   = 2'd3;

  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_block;  // capture the input block
    logic    kx_init;     // load the prekey window from the key
    logic    kx_step;     // make one round key, write it at rk_idx
    logic    enc_round;   // one forward round at rk_idx
    logic    dec_first;   // decrypt opening: mix rk32, then inverse sbox 7
    logic    dec_round;   // one inverse round at rk_idx
    logic    rd_key;      // read the round key at rd_idx
    rk_idx_t rk_idx;
    rk_idx_t rd_idx;
  } dp_cmd_t;

  function automatic logic [3:0] sbox_fwd(input logic [2:0] b, input logic [3:0] v);
    logic [63:0] t;
    case (b)
      3'd0: t = 64'hc907_24de_b56a_1f83;
      3'd1: t = 64'h43d6_8eb1_a509_72cf;
      3'd2: t = 64'h25b0_4e1d_fac3_9768;
      3'd3: t = 64'he57a_421d_369c_8bf0;
      3'd4: t = 64'hd7e9_a452_6b0c_38f1;
      3'd5: t = 64'h176d_8e30_c9a4_b25f;
      3'd6: t = 64'h0a3d_f19e_b648_5c27;
      default: t = 64'h6539_ac47_b28e_0fd1;
    endcase
    return t[{v, 2'b00} +: 4];
  endfunction

  function automatic logic [3:0] sbox_inv(input logic [2:0] b, input logic [3:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int j = 0; j < 16; j++) begin
      if (sbox_fwd(b, 4'(j)) == v) r = 4'(j);
    end
    return r;
  endfunction

  function automatic logic [127:0] sbox_slice(input logic [2:0] b, input logic inv,
                                              input logic [127:0] x);
    logic [127:0] y;
    logic [3:0] v;
    logic [3:0] o;
    y = '0;
    for (int i = 0; i < 32; i++) begin
      v = {x[96+i], x[64+i], x[32+i], x[i]};
      o = inv ? sbox_inv(b, v) : sbox_fwd(b, v);
      y[i] = o[0]; y[32+i] = o[1]; y[64+i] = o[2]; y[96+i] = o[3];
    end
    return y;
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic logic [127:0] lt_fwd(input logic [127:0] s);
    logic [31:0] x0, x1, x2, x3;
    {x3, x2, x1, x0} = s;
    x0 = rol(x0, 13); x2 = rol(x2, 3);
    x1 = x1 ^ x0 ^ x2; x3 = x3 ^ x2 ^ (x0 << 3);
    x1 = rol(x1, 1); x3 = rol(x3, 7);
    x0 = x0 ^ x1 ^ x3; x2 = x2 ^ x3 ^ (x1 << 7);
    x0 = rol(x0, 5); x2 = rol(x2, 22);
    return {x3, x2, x1, x0};
  endfunction

  function automatic logic [127:0] lt_inv(input logic [127:0] s);
    logic [31:0] x0, x1, x2, x3;
    {x3, x2, x1, x0} = s;
    x2 = rol(x2, 10); x0 = rol(x0, 27);
    x2 = x2 ^ x3 ^ (x1 << 7); x0 = x0 ^ x1 ^ x3;
    x3 = rol(x3, 25); x1 = rol(x1, 31);
    x3 = x3 ^ x2 ^ (x0 << 3); x1 = x1 ^ x0 ^ x2;
    x2 = rol(x2, 29); x0 = rol(x0, 19);
    return {x3, x2, x1, x0};
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/serpent_block_cipher_core.sv */
// ----------------------------------------------------------------------------
// Serpent block cipher core
// 256-bit key Serpent, encrypt or decrypt one 128-bit word per run.
// ----------------------------------------------------------------------------
// A new word is accepted only in idle, after the previous result has been taken.
// The round unit does one round a cycle, reading one round key per cycle from the
// round key memory.
// A key write makes the next word first expand 33 round keys, one per cycle.
// Reset (synchronous, rst_n low) marks the keys stale and idles the core.
`default_nettype none
module serpent_block_cipher_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // in_word0, in_word1, in_word2, in_word3
  input  wire logic         in_tuser,  // opcode
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata  // out_word0, out_word1, out_word2, out_word3
);

  srp_pkg::dp_cmd_t cmd;

  srp_ctrl u_ctrl (
    .clk, .rst_n, .cfg_we, .in_tvalid, .in_tready, .in_op(in_tuser),
    .out_tvalid, .out_tready, .cmd
  );

  srp_datapath u_dp (
    .clk, .rst_n, .cmd, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .blk_in(in_tdata), .blk_out(out_tdata)
  );

endmodule
`default_nettype wire

/* hw/rtl/srp_datapath.sv */
// ----------------------------------------------------------------------------
// Serpent datapath
// Key registers, prekey window, round key memory and the round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module srp_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire srp_pkg::dp_cmd_t cmd,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_idx,
  input  wire logic [63:0]     cfg_data,
  input  wire logic [127:0]    blk_in,
  output logic [127:0]         blk_out
);

  logic [63:0]  key_r [4];
  logic [31:0]  win_r [8];
  logic [31:0]  win_nxt [8];
  logic [127:0] rk_mem [srp_pkg::NumRoundKeys];
  logic [127:0] rk_q_r;
  logic [127:0] st_r;
  logic [127:0] st_nxt;
  logic [127:0] kx_pre;
  logic [127:0] t;

  // Four new prekeys per step; index of the first new one minus 8 is 4*rk_idx.
  always_comb begin
    logic [31:0] w [12];
    logic [31:0] base;
    base = {24'd0, cmd.rk_idx, 2'b00};
    for (int i = 0; i < 8; i++) w[i] = win_r[i];
    for (int i = 8; i < 12; i++) begin
      w[i] = srp_pkg::rol(w[i-8] ^ w[i-5] ^ w[i-3] ^ w[i-1] ^ srp_pkg::PhiWord ^
                          (base + 32'(i - 8)), 11);
    end
    for (int i = 0; i < 8; i++) win_nxt[i] = w[i+4];
    kx_pre = {w[11], w[10], w[9], w[8]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (cfg_we) begin
      key_r[cfg_idx] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.kx_init) begin
      for (int i = 0; i < 4; i++) begin
        win_r[2*i]   <= key_r[i][31:0];
        win_r[2*i+1] <= key_r[i][63:32];
      end
    end else if (cmd.kx_step) begin
      win_r <= win_nxt;
      rk_mem[cmd.rk_idx] <= srp_pkg::sbox_slice(3'(6'd35 - cmd.rk_idx), 1'b0, kx_pre);
    end
    if (cmd.rd_key) rk_q_r <= rk_mem[cmd.rd_idx];
    st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    t = '0;
    if (cmd.load_block) begin
      st_nxt = blk_in;
    end else if (cmd.enc_round) begin
      t = srp_pkg::sbox_slice(cmd.rk_idx[2:0], 1'b0, st_r ^ rk_q_r);
      st_nxt = (cmd.rk_idx == 6'd31) ? t : srp_pkg::lt_fwd(t);
    end else if (cmd.dec_first) begin
      st_nxt = srp_pkg::sbox_slice(3'd7, 1'b1, st_r ^ rk_q_r);
    end else if (cmd.dec_round) begin
      t = st_r ^ rk_q_r;
      st_nxt = srp_pkg::sbox_slice(cmd.rk_idx[2:0], 1'b1, srp_pkg::lt_inv(t));
    end else if (cmd.rd_key && cmd.rk_idx == 6'd63) begin
      // Closing key mix.
      st_nxt = st_r ^ rk_q_r;
    end
  end

  assign blk_out = st_r;

endmodule
`default_nettype wire

/* hw/rtl/srp_ctrl.sv */
// ----------------------------------------------------------------------------
// Serpent controller
// Sequences key expansion, the rounds and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module srp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic             in_op,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output srp_pkg::dp_cmd_t      cmd
);

  typedef enum logic [5:0] {
    StIdle  = 6'b000001,
    StKx    = 6'b000010,
    StPrep  = 6'b000100,
    StRound = 6'b001000,
    StFin   = 6'b010000,
    StOut   = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  logic    stale_r, stale_nxt;
  logic    dec_r, dec_nxt;
  srp_pkg::rk_idx_t cnt_r, cnt_nxt;
  logic    accept;

  assign in_tready  = (state_r == StIdle);
  assign out_tvalid = (state_r == StOut);
  assign accept     = in_tvalid && in_tready;

  // Decrypt counts rounds downward and reads the key at cnt; encrypt reads one ahead.
  always_comb begin
    state_nxt = state_r;
    stale_nxt = stale_r | cfg_we;
    dec_nxt   = dec_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.rk_idx = cnt_r;
    case (state_r)
      StIdle: begin
        if (accept) begin
          cmd.load_block = 1'b1;
          dec_nxt = (in_op == srp_pkg::OpDecrypt);
          cnt_nxt = '0;
          if (stale_r) begin
            cmd.kx_init = 1'b1;
            state_nxt = StKx;
          end else begin
            state_nxt = StPrep;
          end
        end
      end
      StKx: begin
        cmd.kx_step = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          stale_nxt = 1'b0;
          state_nxt = StPrep;
        end
      end
      StPrep: begin
        cmd.rd_key = 1'b1;
        cmd.rd_idx = dec_r ? 6'd32 : 6'd0;
        cnt_nxt = dec_r ? 6'd31 : 6'd0;
        state_nxt = StRound;
      end
      StRound: begin
        cmd.rd_key = 1'b1;
        if (!dec_r) begin
          cmd.enc_round = 1'b1;
          cmd.rd_idx = cnt_r + 6'd1;
          cnt_nxt = cnt_r + 6'd1;
          if (cnt_r == 6'd31) state_nxt = StFin;
        end else begin
          if (cnt_r == 6'd31) cmd.dec_first = 1'b1;
          else cmd.dec_round = 1'b1;
          cmd.rd_idx = cnt_r;
          cnt_nxt = cnt_r - 6'd1;
          if (cnt_r == 6'd0) state_nxt = StFin;
        end
      end
      StFin: begin
        cmd.rk_idx = 6'd63;
        cmd.rd_key = 1'b1;
        state_nxt = StOut;
      end
      StOut: begin
        if (out_tready) state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      stale_r <= 1'b1;
      dec_r   <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      stale_r <= stale_nxt;
      dec_r   <= dec_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_kx_stale: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StKx) |-> stale_r) else $error("expansion with fresh keys");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != StIdle) |-> !in_tready) else $error("ready while busy");

endmodule
`default_nettype wire

/* tb/serpent_block_cipher_core_tb.sv */
// ----------------------------------------------------------------------------
// Serpent block cipher core testbench
// Drives encrypt and decrypt words under several keys with random idling on
// both streams, predicts each output word with a local Serpent model and
// compares every output word field by field.
// ----------------------------------------------------------------------------
module serpent_block_cipher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 80;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // in_word0, in_word1, in_word2, in_word3
  logic         in_tuser = 1'b0; // opcode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;       // out_word0, out_word1, out_word2, out_word3

  serpent_block_cipher_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Forward S-box rows, entry v at nibble v.
  localparam logic [63:0] SboxRows [8] = '{
    64'hc90724deb56a1f83, 64'h43d68eb1a50972cf, 64'h25b04e1dfac39768,
    64'he57a421d369c8bf0, 64'hd7e9a4526b0c38f1, 64'h176d8e30c9a4b25f,
    64'h0a3df19eb6485c27, 64'h6539ac47b28e0fd1};

  logic [63:0]  key_regs [4];
  logic [127:0] subkeys [33];
  logic         keys_stale;
  logic [127:0] expected_words [$];
  int           fail_count = 0;
  int           cycle_count = 0;
  int           words_sent = 0;
  int           words_checked = 0;
  int           hold_off_cycles = 0;
  int           rx_wait = 0;
  bit           random_stall = 1'b1;

  function automatic logic [3:0] nibble_map(int b, logic [3:0] v, bit inv);
    logic [3:0] r;
    r = '0;
    if (!inv) return SboxRows[b][v*4 +: 4];
    for (int j = 0; j < 16; j++)
      if (SboxRows[b][j*4 +: 4] == v) r = 4'(j);
    return r;
  endfunction

  function automatic logic [127:0] slice_sbox(int b, bit inv, logic [127:0] x);
    logic [127:0] y;
    logic [3:0] v;
    y = '0;
    for (int i = 0; i < 32; i++) begin
      v = nibble_map(b, {x[96+i], x[64+i], x[32+i], x[i]}, inv);
      {y[96+i], y[64+i], y[32+i], y[i]} = v;
    end
    return y;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (n % 32 == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  function automatic logic [127:0] mix_forward(logic [127:0] s);
    logic [31:0] a, b, c, d;
    {d, c, b, a} = s;
    a = rotl(a, 13); c = rotl(c, 3);
    b ^= a ^ c; d ^= c ^ (a << 3);
    b = rotl(b, 1); d = rotl(d, 7);
    a ^= b ^ d; c ^= d ^ (b << 7);
    a = rotl(a, 5); c = rotl(c, 22);
    return {d, c, b, a};
  endfunction

  function automatic logic [127:0] mix_backward(logic [127:0] s);
    logic [31:0] a, b, c, d;
    {d, c, b, a} = s;
    c = rotl(c, 10); a = rotl(a, 27);
    c ^= d ^ (b << 7); a ^= b ^ d;
    d = rotl(d, 25); b = rotl(b, 31);
    d ^= c ^ (a << 3); b ^= a ^ c;
    c = rotl(c, 29); a = rotl(a, 19);
    return {d, c, b, a};
  endfunction

  task automatic expand_round_keys();
    logic [31:0] w [140];
    for (int i = 0; i < 4; i++) begin
      w[2*i] = key_regs[i][31:0];
      w[2*i+1] = key_regs[i][63:32];
    end
    for (int i = 8; i < 140; i++)
      w[i] = rotl(w[i-8] ^ w[i-5] ^ w[i-3] ^ w[i-1] ^ srp_pkg::PhiWord ^ 32'(i - 8), 11);
    for (int k = 0; k < 33; k++)
      subkeys[k] = slice_sbox((35 - k) % 8, 1'b0,
                              {w[11+4*k], w[10+4*k], w[9+4*k], w[8+4*k]});
  endtask

  task automatic predict_cipher(logic op, logic [127:0] blk);
    logic [127:0] x;
    if (keys_stale) begin
      expand_round_keys();
      keys_stale = 1'b0;
    end
    x = blk;
    if (op == srp_pkg::OpEncrypt) begin
      for (int r = 0; r < 31; r++)
        x = mix_forward(slice_sbox(r % 8, 1'b0, x ^ subkeys[r]));
      x = slice_sbox(7, 1'b0, x ^ subkeys[31]) ^ subkeys[32];
    end else begin
      x = slice_sbox(7, 1'b1, x ^ subkeys[32]) ^ subkeys[31];
      for (int r = 30; r >= 0; r--)
        x = slice_sbox(r % 8, 1'b1, mix_backward(x)) ^ subkeys[r];
    end
    expected_words.push_back(x);
  endtask

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  // The valid line stays up after the handshake; the caller or the next gap drops it.
  task automatic send_word(logic op, logic [127:0] blk, bit gaps = 1'b1);
    int idle;
    idle = gaps ? int'($urandom_range(0, 8)) : 0;
    if (idle > 0) begin
      in_tvalid <= 1'b0;
      wait_cycles(idle);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= blk;
    predict_cipher(op, blk);
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    wait_cycles(SettleCycles);
  endtask

  task automatic write_key(logic [1:0] idx, logic [63:0] val, bit last = 1'b1);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (last) cfg_we <= 1'b0;
    key_regs[idx] = val;
    keys_stale = 1'b1;
  endtask

  task automatic load_key(logic [255:0] k);
    write_key(srp_pkg::CfgKeyLowPair, k[63:0], 1'b0);
    write_key(srp_pkg::CfgKeySecondPair, k[127:64], 1'b0);
    write_key(srp_pkg::CfgKeyThirdPair, k[191:128], 1'b0);
    write_key(srp_pkg::CfgKeyHighPair, k[255:192]);
  endtask

  function automatic logic [127:0] rand_block();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [255:0] rand_key();
    return {rand_block(), rand_block()};
  endfunction

  // Reset key of all zeros, then field extremes under each operation.
  task automatic test_directed();
    logic [127:0] pats [6];
    pats = '{'0, '1, {4{32'h0000_0001}}, {4{32'h8000_0000}},
             128'h0123456789abcdeffedcba9876543210, {64'h0, 64'hffff_ffff_ffff_ffff}};
    foreach (pats[i]) begin
      send_word(srp_pkg::OpEncrypt, pats[i]);
      send_word(srp_pkg::OpDecrypt, pats[i]);
    end
    drain();
    load_key('1);
    foreach (pats[i])
      send_word(i % 2 ? srp_pkg::OpDecrypt : srp_pkg::OpEncrypt, pats[i]);
    drain();
    // A rewrite with the same value still forces a fresh expansion.
    write_key(srp_pkg::CfgKeyHighPair, key_regs[srp_pkg::CfgKeyHighPair]);
    send_word(srp_pkg::OpEncrypt, '1);
    drain();
  endtask

  task automatic test_random_keys();
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) load_key('0);
      else if (phase == 1) load_key({4{64'h8000_0000_0000_0001}});
      else if (phase % 3 == 0) write_key(2'($urandom_range(0, 3)), {$urandom, $urandom});
      else load_key(rand_key());
      for (int i = 0; i < 90; i++)
        send_word(1'($urandom_range(0, 1)), rand_block(), i > 10);
      drain();
    end
  endtask

  // Receiver blocks for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_off_cycles = 300;
    for (int i = 0; i < 20; i++) send_word(1'($urandom_range(0, 1)), rand_block(), 1'b0);
    drain();
    // Sender pauses until everything is back before each new word.
    for (int i = 0; i < 20; i++) begin
      send_word(1'($urandom_range(0, 1)), rand_block(), 1'b0);
      in_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  // After each accepted word the receiver idles for a drawn number of cycles while random_stall is set.
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      n = random_stall ? int'($urandom_range(0, 8)) : 0;
      rx_wait <= n;
      out_tready <= (n == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_tready <= (rx_wait == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [127:0] exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word %h", out_tdata);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        for (int f = 0; f < 4; f++)
          if (exp_w[f*32 +: 32] !== out_tdata[f*32 +: 32]) begin
            $error("out_word%0d expected %h actual %h", f, exp_w[f*32 +: 32],
                   out_tdata[f*32 +: 32]);
            fail_count++;
          end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    foreach (key_regs[i]) key_regs[i] = '0;
    keys_stale = 1'b1;
    wait_cycles(12);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_keys();
    test_backpressure();
    random_stall = 1'b0;
    for (int i = 0; i < 30; i++) send_word(1'($urandom_range(0, 1)), rand_block(), 1'b0);
    drain();
    $display("Sent %0d words, checked %0d, encrypt and decrypt over several keys.",
             words_sent, words_checked);
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/srp_pkg.sv
hw/rtl/srp_datapath.sv
hw/rtl/srp_ctrl.sv
hw/rtl/serpent_block_cipher_core.sv
tb/serpent_block_cipher_core_tb.sv
